/* hw/rtl/lhct_pkg.sv */
`default_nettype none
package lhct_pkg;

	// table geometry
	localparam int TABLE_SLOTS = 1499;
	localparam int SLOT_W      = $clog2(TABLE_SLOTS);
	localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(TABLE_SLOTS - 1);
	localparam logic [CNT_W-1:0]  CNT_LAST  = CNT_W'(TABLE_SLOTS - 1);

	// payload widths
	localparam int KEY_W  = 64;
	localparam int HASH_W = KEY_W / 2;
	localparam int TICK_W = 32;
	localparam int HND_W  = 32;
	localparam int STAT_W = 2;
	localparam logic [TICK_W-1:0] SIGN_BIAS = {1'b1, {(TICK_W-1){1'b0}}};
	localparam logic [TICK_W-1:0] AGE_FLOOR = {1'b0, {(TICK_W-1){1'b1}}};

	// home slot reduction: quotient estimate by reciprocal, then one correction
	localparam int HCNT_W     = 2;
	localparam logic [HCNT_W-1:0] HASH_LAST = 2'd2;
	localparam int HASH_SHIFT = HASH_W + SLOT_W - 1;
	localparam logic [HASH_W-1:0] HASH_RECIP =
		HASH_W'((64'd1 << HASH_SHIFT) / 64'(TABLE_SLOTS));

	// capacity register
	localparam int MAXE_W = 11;
	localparam logic [MAXE_W-1:0] MAXE_RESET = 11'd1024;
	localparam int CMP_W = (CNT_W > MAXE_W) ? CNT_W : MAXE_W;

	// APB
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_MAX_ENTRIES = 1'b0; // register index, paddr[2]

	// commands and result status
	localparam logic CMD_LOOKUP = 1'b0;
	localparam logic CMD_INSERT = 1'b1;
	localparam logic [STAT_W-1:0] ST_HIT      = 2'd0;
	localparam logic [STAT_W-1:0] ST_MISS     = 2'd1;
	localparam logic [STAT_W-1:0] ST_INSERTED = 2'd2;
	localparam logic [STAT_W-1:0] ST_EVICTED  = 2'd3;

	// datapath walking modes
	localparam logic [2:0] MODE_NONE  = 3'd0;
	localparam logic [2:0] MODE_CLEAR = 3'd1;
	localparam logic [2:0] MODE_HASH  = 3'd2;
	localparam logic [2:0] MODE_SCAN  = 3'd3;
	localparam logic [2:0] MODE_PROBE = 3'd4;

	typedef struct packed {
		logic       load;
		logic [2:0] mode;
		logic       evict;
		logic       write;
		logic       fin;
	} dp_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic hash_done;
		logic scan_done;
		logic probe_done;
		logic probe_found;
		logic key_zero;
		logic is_insert;
		logic evict_due;
	} dp_sts_t;

endpackage
`default_nettype wire

/* hw/rtl/lhct_ram.sv */
`default_nettype none
module lhct_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule
`default_nettype wire

/* hw/rtl/lhct_ctrl.sv */
`default_nettype none
module lhct_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire lhct_pkg::dp_sts_t sts,
	output lhct_pkg::dp_cmd_t      cmd
);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_HASH  = 3'd2;
	localparam logic [2:0] S_SCAN  = 3'd3;
	localparam logic [2:0] S_EVICT = 3'd4;
	localparam logic [2:0] S_PROBE = 3'd5;
	localparam logic [2:0] S_WRITE = 3'd6;
	localparam logic [2:0] S_FIN   = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		cmd.mode  = lhct_pkg::MODE_NONE;
		case (state_q)
			S_CLEAR: begin
				cmd.mode = lhct_pkg::MODE_CLEAR;
				if (sts.clr_done) begin
					state_nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.load  = 1'b1;
					state_nxt = S_HASH;
				end
			end
			S_HASH: begin
				cmd.mode = lhct_pkg::MODE_HASH;
				if (sts.hash_done) begin
					if (sts.key_zero) begin
						state_nxt = S_FIN;
					end else if (sts.is_insert && sts.evict_due) begin
						state_nxt = S_SCAN;
					end else begin
						state_nxt = S_PROBE;
					end
				end
			end
			S_SCAN: begin
				cmd.mode = lhct_pkg::MODE_SCAN;
				if (sts.scan_done) begin
					state_nxt = S_EVICT;
				end
			end
			S_EVICT: begin
				cmd.evict = 1'b1;
				state_nxt = S_PROBE;
			end
			S_PROBE: begin
				cmd.mode = lhct_pkg::MODE_PROBE;
				if (sts.probe_done) begin
					state_nxt = sts.probe_found ? S_WRITE : S_FIN;
				end
			end
			S_WRITE: begin
				cmd.write = 1'b1;
				state_nxt = S_FIN;
			end
			S_FIN: begin
				cmd.fin   = 1'b1;
				state_nxt = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule
`default_nettype wire

/* hw/rtl/lhct_dp.sv */
`default_nettype none
module lhct_dp (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire lhct_pkg::dp_cmd_t                   cmd,
	output lhct_pkg::dp_sts_t                        sts,
	input  wire logic [lhct_pkg::MAXE_W-1:0]         max_entries,
	input  wire logic                                command,
	input  wire logic [lhct_pkg::KEY_W-1:0]          quad_key,
	input  wire logic [lhct_pkg::TICK_W-1:0]         current_tick,
	input  wire logic [lhct_pkg::HND_W-1:0]          new_handle,
	output logic                                     done,
	output logic      [lhct_pkg::STAT_W-1:0]         status,
	output logic      [lhct_pkg::SLOT_W-1:0]         slot,
	output logic      [lhct_pkg::HND_W-1:0]          handle,
	output logic      [lhct_pkg::HND_W-1:0]          evicted_handle
);

	// request registers
	logic                          cmd_q;
	logic [lhct_pkg::KEY_W-1:0]    key_q;
	logic [lhct_pkg::TICK_W-1:0]   tick_q;
	logic [lhct_pkg::HND_W-1:0]    nh_q;

	// home slot reduction
	logic [lhct_pkg::HASH_W-1:0]   h_q;
	logic [2*lhct_pkg::HASH_W-1:0] prod_q;
	logic [lhct_pkg::SLOT_W:0]     diff_q;
	logic [lhct_pkg::SLOT_W-1:0]   rem_q;
	logic [lhct_pkg::HCNT_W-1:0]   hcnt_q;
	logic [lhct_pkg::HASH_W-1:0]   quot;
	logic [lhct_pkg::HASH_W-1:0]   qmul;
	logic                          diff_ge;

	// walk over the table
	logic                          act_q;
	logic [lhct_pkg::SLOT_W-1:0]   ptr_q;
	logic                          cmp_vld_q;
	logic [lhct_pkg::SLOT_W-1:0]   cmp_addr_q;
	logic [lhct_pkg::CNT_W-1:0]    cmp_cnt_q;
	logic [lhct_pkg::SLOT_W-1:0]   clr_ptr_q;
	logic [lhct_pkg::SLOT_W-1:0]   rd_addr;
	logic [lhct_pkg::SLOT_W-1:0]   start_addr;
	logic                          scanning;
	logic                          probing;
	logic                          walking;
	logic                          cmp_last;
	logic                          match;

	// victim search
	logic [lhct_pkg::SLOT_W-1:0]   vic_slot_q;
	logic [lhct_pkg::HND_W-1:0]    vic_hnd_q;
	logic                          vic_live_q;
	logic [lhct_pkg::TICK_W-1:0]   best_age_q;
	logic [lhct_pkg::TICK_W-1:0]   age_b;
	logic                          rd_live;

	// outcome
	logic                          found_q;
	logic [lhct_pkg::SLOT_W-1:0]   found_slot_q;
	logic [lhct_pkg::HND_W-1:0]    found_hnd_q;
	logic                          evicted_q;
	logic [lhct_pkg::HND_W-1:0]    ev_hnd_q;
	logic [lhct_pkg::CNT_W-1:0]    live_q;

	// memories
	logic [lhct_pkg::KEY_W-1:0]    key_rd;
	logic [lhct_pkg::HND_W-1:0]    hnd_rd;
	logic [lhct_pkg::TICK_W-1:0]   tick_rd;
	logic [lhct_pkg::SLOT_W-1:0]   wr_addr;
	logic [lhct_pkg::KEY_W-1:0]    wr_key;
	logic                          key_we;
	logic                          hnd_we;
	logic                          tick_we;
	logic [lhct_pkg::KEY_W-1:0]    want;

	assign scanning = (cmd.mode == lhct_pkg::MODE_SCAN);
	assign probing  = (cmd.mode == lhct_pkg::MODE_PROBE);
	assign walking  = scanning || probing;

	assign start_addr = scanning ? '0 : rem_q;
	assign rd_addr    = act_q ? ptr_q : start_addr;
	assign cmp_last   = cmp_vld_q && (cmp_cnt_q == lhct_pkg::CNT_LAST);

	// insert probes for an empty slot, lookup for the key itself
	assign want  = (cmd_q == lhct_pkg::CMD_INSERT) ? '0 : key_q;
	assign match = probing && cmp_vld_q && (key_rd == want);

	assign rd_live = (key_rd != '0);
	assign age_b   = (tick_q - tick_rd) ^ lhct_pkg::SIGN_BIAS;

	// quotient estimate is exact or one short, so the difference is below 2*TABLE_SLOTS
	assign quot    = lhct_pkg::HASH_W'(prod_q >> lhct_pkg::HASH_SHIFT);
	assign qmul    = quot * lhct_pkg::HASH_W'(lhct_pkg::TABLE_SLOTS);
	assign diff_ge = (diff_q >= (lhct_pkg::SLOT_W+1)'(lhct_pkg::TABLE_SLOTS));

	always_comb begin
		sts             = '0;
		sts.clr_done    = (clr_ptr_q == lhct_pkg::SLOT_LAST);
		sts.hash_done   = (hcnt_q == lhct_pkg::HASH_LAST);
		sts.scan_done   = scanning && cmp_last;
		sts.probe_done  = match || (probing && cmp_last);
		sts.probe_found = match;
		sts.key_zero    = (key_q == '0);
		sts.is_insert   = (cmd_q == lhct_pkg::CMD_INSERT);
		sts.evict_due   = (lhct_pkg::CMP_W'(live_q) >= lhct_pkg::CMP_W'(max_entries));
	end

	// write port selection
	always_comb begin
		wr_addr = found_slot_q;
		wr_key  = '0;
		key_we  = 1'b0;
		hnd_we  = 1'b0;
		tick_we = 1'b0;
		if (cmd.mode == lhct_pkg::MODE_CLEAR) begin
			wr_addr = clr_ptr_q;
			key_we  = 1'b1;
		end else if (cmd.evict) begin
			wr_addr = vic_slot_q;
			key_we  = vic_live_q;
		end else if (cmd.write) begin
			tick_we = 1'b1;
			if (cmd_q == lhct_pkg::CMD_INSERT) begin
				wr_key = key_q;
				key_we = 1'b1;
				hnd_we = 1'b1;
			end
		end
	end

	// request capture and modulo: product, difference, correction
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q  <= command;
			key_q  <= quad_key;
			tick_q <= current_tick;
			nh_q   <= new_handle;
			h_q    <= quad_key[lhct_pkg::HASH_W-1:0] ^ quad_key[lhct_pkg::KEY_W-1:lhct_pkg::HASH_W];
		end else if (cmd.mode == lhct_pkg::MODE_HASH) begin
			prod_q <= (2*lhct_pkg::HASH_W)'(h_q) * (2*lhct_pkg::HASH_W)'(lhct_pkg::HASH_RECIP);
			diff_q <= (lhct_pkg::SLOT_W+1)'(h_q - qmul);
			rem_q  <= diff_ge ? lhct_pkg::SLOT_W'(diff_q - (lhct_pkg::SLOT_W+1)'(lhct_pkg::TABLE_SLOTS))
			                  : diff_q[lhct_pkg::SLOT_W-1:0];
		end
	end

	// walk control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hcnt_q    <= '0;
			act_q     <= 1'b0;
			cmp_vld_q <= 1'b0;
			cmp_cnt_q <= '0;
			clr_ptr_q <= '0;
		end else begin
			if (cmd.load) begin
				hcnt_q <= '0;
			end else if (cmd.mode == lhct_pkg::MODE_HASH) begin
				hcnt_q <= hcnt_q + 1'b1;
			end
			if (cmd.mode == lhct_pkg::MODE_CLEAR) begin
				clr_ptr_q <= clr_ptr_q + 1'b1;
			end
			if (walking) begin
				act_q     <= 1'b1;
				cmp_vld_q <= 1'b1;
				if (cmp_vld_q) begin
					cmp_cnt_q <= cmp_cnt_q + 1'b1;
				end
			end else begin
				act_q     <= 1'b0;
				cmp_vld_q <= 1'b0;
				cmp_cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (walking) begin
			ptr_q      <= (rd_addr == lhct_pkg::SLOT_LAST) ? '0 : rd_addr + 1'b1;
			cmp_addr_q <= rd_addr;
		end
	end

	// oldest live entry, ties to lowest slot, slot 0 when no age is non-negative
	always_ff @(posedge clk) begin
		if (scanning && cmp_vld_q) begin
			if (cmp_cnt_q == '0) begin
				vic_slot_q <= '0;
				vic_hnd_q  <= hnd_rd;
				vic_live_q <= rd_live;
				best_age_q <= (rd_live && (age_b > lhct_pkg::AGE_FLOOR)) ? age_b
				                                                         : lhct_pkg::AGE_FLOOR;
			end else if (rd_live && (age_b > best_age_q)) begin
				vic_slot_q <= cmp_addr_q;
				vic_hnd_q  <= hnd_rd;
				vic_live_q <= 1'b1;
				best_age_q <= age_b;
			end
		end
	end

	// outcome and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q   <= 1'b0;
			evicted_q <= 1'b0;
			live_q    <= '0;
		end else begin
			if (cmd.load) begin
				found_q   <= 1'b0;
				evicted_q <= 1'b0;
			end else if (match) begin
				found_q <= 1'b1;
			end
			if (cmd.evict && vic_live_q) begin
				evicted_q <= 1'b1;
				live_q    <= live_q - 1'b1;
			end else if (cmd.write && (cmd_q == lhct_pkg::CMD_INSERT)) begin
				live_q <= live_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (match) begin
			found_slot_q <= cmp_addr_q;
			found_hnd_q  <= hnd_rd;
		end
		if (cmd.evict) begin
			ev_hnd_q <= vic_hnd_q;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cmd.fin;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			if ((key_q == '0) || !found_q) begin
				status         <= lhct_pkg::ST_MISS;
				slot           <= '0;
				handle         <= '0;
				evicted_handle <= '0;
			end else if (cmd_q == lhct_pkg::CMD_LOOKUP) begin
				status         <= lhct_pkg::ST_HIT;
				slot           <= found_slot_q;
				handle         <= found_hnd_q;
				evicted_handle <= '0;
			end else begin
				status         <= evicted_q ? lhct_pkg::ST_EVICTED : lhct_pkg::ST_INSERTED;
				slot           <= found_slot_q;
				handle         <= nh_q;
				evicted_handle <= evicted_q ? ev_hnd_q : '0;
			end
		end
	end

	lhct_ram #(
		.WIDTH (lhct_pkg::KEY_W),
		.DEPTH (lhct_pkg::TABLE_SLOTS)
	) u_key_ram (
		.clk     (clk),
		.we      (key_we),
		.wr_addr (wr_addr),
		.wr_data (wr_key),
		.rd_addr (rd_addr),
		.rd_data (key_rd)
	);

	lhct_ram #(
		.WIDTH (lhct_pkg::HND_W),
		.DEPTH (lhct_pkg::TABLE_SLOTS)
	) u_hnd_ram (
		.clk     (clk),
		.we      (hnd_we),
		.wr_addr (wr_addr),
		.wr_data (nh_q),
		.rd_addr (rd_addr),
		.rd_data (hnd_rd)
	);

	lhct_ram #(
		.WIDTH (lhct_pkg::TICK_W),
		.DEPTH (lhct_pkg::TABLE_SLOTS)
	) u_tick_ram (
		.clk     (clk),
		.we      (tick_we),
		.wr_addr (wr_addr),
		.wr_data (tick_q),
		.rd_addr (rd_addr),
		.rd_data (tick_rd)
	);

endmodule
`default_nettype wire

/* hw/rtl/lru_hash_cache_table_core.sv */
// Sequence: request accepted, reciprocal home slot reduction, pipelined probe of k slots,
//   k = 1..TABLE_SLOTS starting at the home slot, then write-back and result in that order.
//   A lookup miss or full table skips the write-back; a zero key skips probe and write-back.
//   An insert that meets the capacity adds a full LRU scan and the eviction before the probe.
// Throughput: one request at a time; the single read port of the slot memories sets the pace.
// Reset: arst_n clears control at once, then a clearing pass over all TABLE_SLOTS (1499) slots
//   empties the key store; busy stays high until it ends. Results cannot be stalled.
`default_nettype none
module lru_hash_cache_table_core (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// APB configuration port
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [lhct_pkg::PADDR_W-1:0]        paddr,
	input  wire logic [lhct_pkg::PDATA_W-1:0]        pwdata,
	output logic      [lhct_pkg::PDATA_W-1:0]        prdata,
	output logic                                     pready,
	// request
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic                                command,
	input  wire logic [lhct_pkg::KEY_W-1:0]          quad_key,
	input  wire logic [lhct_pkg::TICK_W-1:0]         current_tick,
	input  wire logic [lhct_pkg::HND_W-1:0]          new_handle,
	// result
	output logic                                     done,
	output logic      [lhct_pkg::STAT_W-1:0]         status,
	output logic      [lhct_pkg::SLOT_W-1:0]         slot,
	output logic      [lhct_pkg::HND_W-1:0]          handle,
	output logic      [lhct_pkg::HND_W-1:0]          evicted_handle
);

	// Capacity register. Only paddr[2] selects the register; low byte bits are ignored.
	logic [lhct_pkg::MAXE_W-1:0] max_entries_q;
	logic                        reg_sel;
	logic                        reg_wr;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == lhct_pkg::REG_MAX_ENTRIES);
	assign reg_wr  = psel && penable && pwrite && reg_sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_entries_q <= lhct_pkg::MAXE_RESET;
		end else if (reg_wr) begin
			max_entries_q <= pwdata[lhct_pkg::MAXE_W-1:0];
		end
	end

	assign prdata = reg_sel ? lhct_pkg::PDATA_W'(max_entries_q) : '0;

	// Controller sequences hash -> (scan -> evict) -> probe -> (write) -> result, write only on a probe hit;
	// a zero key goes from hash straight to result; the datapath owns the slot memories, counters and result registers.
	lhct_pkg::dp_cmd_t dp_cmd;
	lhct_pkg::dp_sts_t dp_sts;

	lhct_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (dp_sts),
		.cmd    (dp_cmd)
	);

	lhct_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (dp_cmd),
		.sts            (dp_sts),
		.max_entries    (max_entries_q),
		.command        (command),
		.quad_key       (quad_key),
		.current_tick   (current_tick),
		.new_handle     (new_handle),
		.done           (done),
		.status         (status),
		.slot           (slot),
		.handle         (handle),
		.evicted_handle (evicted_handle)
	);

endmodule
`default_nettype wire

/* hw/rtl/lhct_checker.sv */
`default_nettype none
module lhct_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        start,
	input wire logic                        busy,
	input wire logic                        done,
	input wire logic [lhct_pkg::STAT_W-1:0] status,
	input wire logic [lhct_pkg::SLOT_W-1:0] slot,
	input wire logic [lhct_pkg::HND_W-1:0]  handle,
	input wire logic [lhct_pkg::HND_W-1:0]  evicted_handle
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted request did not raise busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == lhct_pkg::ST_MISS) |-> (slot == '0) && (handle == '0)
		&& (evicted_handle == '0))
		else $error("miss with nonzero fields");

	a_evict_only: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != lhct_pkg::ST_EVICTED) |-> (evicted_handle == '0))
		else $error("evicted handle without eviction");

endmodule

bind lru_hash_cache_table_core lhct_checker u_lhct_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.done           (done),
	.status         (status),
	.slot           (slot),
	.handle         (handle),
	.evicted_handle (evicted_handle)
);
`default_nettype wire
